/* rtl/lprs_pkg.sv */
// Package for the length-prefixed record splitter.
// Holds shared constants, codes and the command and queue status types.
// No dependencies.
package lprs_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W      = 3;

	localparam logic [15:0] MAX_RECORD_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_DATA      = 2'd0,
		ST_CLEAN     = 2'd1,
		ST_INVALID   = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_DROP   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_STATUS = 2'd2
	} cmd_kind_t;

	typedef enum logic {
		REG_MAX_RECORD = 1'b0
	} reg_index_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] word;
		logic        rec_last;
		logic        tail_en;
		status_t     tail_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

/* rtl/lprs_in_if.sv */
// Input channel of the record splitter: one payload byte per transfer.
// Depends on nothing.
interface lprs_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_value;
	logic [15:0] payload_bytes;
	logic        payload_last;

	modport source (output valid, output byte_value, output payload_bytes,
		output payload_last, input ready);
	modport sink (input valid, input byte_value, input payload_bytes,
		input payload_last, output ready);
endinterface

/* rtl/lprs_out_if.sv */
// Output channel of the record splitter: one record byte or status per transfer.
// Depends on nothing.
interface lprs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       record_first;
	logic       record_last;
	logic       run_last;
	logic [1:0] status;

	modport source (output valid, output out_byte, output record_first,
		output record_last, output run_last, output status, input ready);
	modport sink (input valid, input out_byte, input record_first,
		input record_last, input run_last, input status, output ready);
endinterface

/* rtl/lprs_front.sv */
// Front end: tracks payload and record position, checks headers, issues commands.
// Depends on lprs_pkg and lprs_in_if.
module lprs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	lprs_in_if.sink              item,
	input  logic [15:0]          max_record_bytes,
	input  lprs_pkg::queue_stat_t qstat,
	output logic                 push,
	output lprs_pkg::cmd_t       cmd
);

	lprs_pkg::phase_t phase_q, phase_d;
	logic [15:0] off_q, off_d;
	logic [23:0] hstore_q, hstore_d;
	logic [1:0]  hcount_q, hcount_d;
	logic [15:0] brem_q, brem_d;

	logic        acc;
	logic        end_w;
	logic [16:0] off_inc;
	logic [16:0] eff;
	logic [15:0] start;
	logic [31:0] len32;
	logic        c_short;
	logic        c_len_bad;
	logic        c_big;
	logic        done;

	assign item.ready = !qstat.full;
	assign acc        = item.valid && item.ready;

	assign off_inc = {1'b0, off_q} + 17'd1;
	assign end_w   = item.payload_last || (off_inc >= {1'b0, item.payload_bytes});
	assign eff     = item.payload_last ? off_inc : {1'b0, item.payload_bytes};
	assign start   = off_q - {14'd0, hcount_q};
	assign len32   = {item.byte_value, hstore_q};
	assign c_short = ({2'b00, start} + 18'(lprs_pkg::HEADER_BYTES)) >= {1'b0, eff};
	assign c_len_bad = (len32 == 32'd0) || (len32[31:16] != 16'd0) ||
		(({2'b00, start} + 18'(lprs_pkg::HEADER_BYTES) + {2'b00, len32[15:0]})
			> {1'b0, eff});
	assign c_big = ({1'b0, len32[15:0]} + 17'(lprs_pkg::HEADER_BYTES))
		> {1'b0, max_record_bytes};
	assign done  = brem_q <= 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lprs_pkg::PH_HEADER;
			off_q    <= '0;
			hstore_q <= '0;
			hcount_q <= '0;
			brem_q   <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			off_q    <= off_d;
			hstore_q <= hstore_d;
			hcount_q <= hcount_d;
			brem_q   <= brem_d;
		end
	end

	always_comb begin
		phase_d         = phase_q;
		hstore_d        = hstore_q;
		hcount_d        = hcount_q;
		brem_d          = brem_q;
		off_d           = off_inc[15:0];
		push            = 1'b0;
		cmd.kind        = lprs_pkg::CMD_STATUS;
		cmd.word        = {24'd0, item.byte_value};
		cmd.rec_last    = 1'b0;
		cmd.tail_en     = 1'b0;
		cmd.tail_status = lprs_pkg::ST_INVALID;
		unique case (phase_q)
			lprs_pkg::PH_HEADER: begin
				if (c_short) begin
					push     = acc;
					phase_d  = lprs_pkg::PH_DROP;
					hstore_d = '0;
					hcount_d = '0;
				end else if (hcount_q != 2'd3) begin
					hstore_d = hstore_q | (24'(item.byte_value) << {hcount_q, 3'b000});
					hcount_d = hcount_q + 2'd1;
				end else begin
					push     = acc;
					hstore_d = '0;
					hcount_d = '0;
					if (c_len_bad) begin
						phase_d = lprs_pkg::PH_DROP;
					end else if (c_big) begin
						phase_d         = lprs_pkg::PH_DROP;
						cmd.tail_status = lprs_pkg::ST_TOO_LARGE;
					end else begin
						cmd.kind = lprs_pkg::CMD_HEADER;
						cmd.word = len32;
						brem_d   = len32[15:0];
						phase_d  = lprs_pkg::PH_BODY;
					end
				end
			end
			lprs_pkg::PH_BODY: begin
				push         = acc;
				cmd.kind     = lprs_pkg::CMD_BYTE;
				cmd.rec_last = done;
				cmd.tail_en  = end_w;
				brem_d       = done ? 16'd0 : brem_q - 16'd1;
				if (done) begin
					phase_d         = lprs_pkg::PH_HEADER;
					cmd.tail_status = lprs_pkg::ST_CLEAN;
				end
			end
			default: begin
			end
		endcase
		if (end_w) begin
			phase_d  = lprs_pkg::PH_HEADER;
			off_d    = '0;
			hstore_d = '0;
			hcount_d = '0;
			brem_d   = '0;
		end
	end

endmodule

/* rtl/lprs_cmd_fifo.sv */
// Command queue between front and back end, flip-flop storage.
// Depends on lprs_pkg.
module lprs_cmd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lprs_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output lprs_pkg::cmd_t        head,
	output lprs_pkg::queue_stat_t qstat
);

	lprs_pkg::cmd_t mem_q [lprs_pkg::QUEUE_DEPTH];
	logic [lprs_pkg::QPTR_W-1:0] wptr_q;
	logic [lprs_pkg::QPTR_W-1:0] rptr_q;
	logic [lprs_pkg::QCNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign qstat.full  = count_q == lprs_pkg::QCNT_W'(lprs_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/lprs_back.sv */
// Back end: expands queued commands into result transfers behind an output register.
// Depends on lprs_pkg and lprs_out_if.
module lprs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lprs_pkg::cmd_t        head,
	input  lprs_pkg::queue_stat_t qstat,
	output logic                  pop,
	lprs_out_if.source            result
);

	logic [1:0] step_q;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       first_q;
	logic       last_q;
	logic       run_q;
	lprs_pkg::status_t status_q;

	logic       issue;
	logic       last_step;
	logic [7:0] r_byte;
	logic       r_first;
	logic       r_last;
	logic       r_run;
	lprs_pkg::status_t r_status;

	assign issue = !qstat.empty && (!ov_q || result.ready);
	assign pop   = issue && last_step;

	always_comb begin
		last_step = 1'b1;
		r_byte    = 8'd0;
		r_first   = 1'b0;
		r_last    = 1'b0;
		r_run     = 1'b1;
		r_status  = head.tail_status;
		unique case (head.kind)
			lprs_pkg::CMD_HEADER: begin
				last_step = step_q == 2'd3;
				r_run     = last_step;
				r_first   = step_q == 2'd0;
				r_status  = lprs_pkg::ST_DATA;
				unique case (step_q)
					2'd0: r_byte = head.word[7:0];
					2'd1: r_byte = head.word[15:8];
					2'd2: r_byte = head.word[23:16];
					2'd3: r_byte = head.word[31:24];
				endcase
			end
			lprs_pkg::CMD_BYTE: begin
				if (step_q == 2'd0) begin
					last_step = !head.tail_en;
					r_run     = !head.tail_en;
					r_byte    = head.word[7:0];
					r_last    = head.rec_last;
					r_status  = lprs_pkg::ST_DATA;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (issue) begin
				step_q <= last_step ? 2'd0 : step_q + 2'd1;
				ov_q   <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			byte_q   <= r_byte;
			first_q  <= r_first;
			last_q   <= r_last;
			run_q    <= r_run;
			status_q <= r_status;
		end
	end

	assign result.valid        = ov_q;
	assign result.out_byte     = byte_q;
	assign result.record_first = first_q;
	assign result.record_last  = last_q;
	assign result.run_last     = run_q;
	assign result.status       = status_q;

endmodule

/* rtl/length_prefixed_record_splitter.sv */
// Top level of the length-prefixed record splitter: register port, front, queue, back.
// Depends on lprs_pkg, lprs_in_if, lprs_out_if, lprs_front, lprs_cmd_fifo, lprs_back.
//
//  channel   direction  per transfer
//  item      in         byte_value, payload_bytes, payload_last
//  result    out        out_byte, record_first, record_last, run_last, status
//  apb       in/out     max_record_bytes at byte address 0
//
// One input byte per cycle unless the four-entry command queue, which absorbs bursts, is
// full; body bytes pass through it to the output register, and a header's last
// byte gives four header results. The back end issues one result per cycle unless the
// queue is empty or the output stalls. Asynchronous active-low reset; max_record_bytes
// resets to 65535. item.ready drops only while the command queue is full.
module length_prefixed_record_splitter (
	input  logic                         clk,
	input  logic                         arst_n,
	lprs_in_if.sink                      item,
	lprs_out_if.source                   result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lprs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [15:0] max_q;
	logic        cfg_wr;
	logic        push;
	logic        pop;
	lprs_pkg::cmd_t        cmd;
	lprs_pkg::cmd_t        head;
	lprs_pkg::queue_stat_t qstat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == lprs_pkg::REG_MAX_RECORD);
	assign prdata = (paddr[2] == lprs_pkg::REG_MAX_RECORD) ? {16'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lprs_pkg::MAX_RECORD_RESET;
		end else if (cfg_wr) begin
			max_q <= pwdata[15:0];
		end
	end

	lprs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (item),
		.max_record_bytes (max_q),
		.qstat            (qstat),
		.push             (push),
		.cmd              (cmd)
	);

	lprs_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	lprs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status != lprs_pkg::ST_DATA) |->
		(result.out_byte == 8'd0) && !result.record_first && !result.record_last &&
		result.run_last)
		else $error("status result carries data flags");

	a_first_not_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.record_first |->
		(result.status == lprs_pkg::ST_DATA) && !result.run_last && !result.record_last)
		else $error("record start ends its run");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.record_last |-> (result.status == lprs_pkg::ST_DATA))
		else $error("record end on status result");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (max_q == $past(pwdata[15:0])))
		else $error("register write lost");

endmodule

/* bench/lprs_record_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the length-prefixed record splitter: watches item, result and APB writes.
// Predicts record beats per payload byte and compares each result transfer.
// Depends on lprs_pkg, lprs_in_if, lprs_out_if.
module lprs_record_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	lprs_in_if                           item_mon,
	lprs_out_if                          result_mon,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lprs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	output int unsigned                  fail_count,
	output int unsigned                  pending
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0]        data;
		logic              first;
		logic              last;
		logic              run_end;
		lprs_pkg::status_t status;
	} beat_t;

	beat_t             beats_due[$];
	lprs_pkg::phase_t  split_phase;
	logic [15:0]       offset;
	logic [23:0]       hdr;
	logic [1:0]        hdr_cnt;
	logic [15:0]       body_left;
	logic [15:0]       max_rec;
	int unsigned       mism = 0;

	function automatic beat_t make_beat(input logic [7:0] b, input logic f, input logic l,
		input lprs_pkg::status_t s);
		beat_t r;
		r.data = b;
		r.first = f;
		r.last = l;
		r.run_end = 1'b0;
		r.status = s;
		return r;
	endfunction

	function automatic void split_byte(input logic [7:0] b, input logic [15:0] pb,
		input logic mark);
		beat_t  burst [4];
		int     n;
		int     i;
		longint pos;
		longint lim;
		longint base;
		longint len;
		logic   at_end;
		logic   done;
		n = 0;
		pos = longint'(offset);
		at_end = mark || (pos + 1 >= longint'(pb));
		lim = mark ? pos + 1 : longint'(pb);
		case (split_phase)
			lprs_pkg::PH_HEADER: begin
				base = pos - longint'(hdr_cnt);
				if (base + lprs_pkg::HEADER_BYTES >= lim) begin
					burst[n] = make_beat(8'h00, 1'b0, 1'b0, lprs_pkg::ST_INVALID);
					n++;
					split_phase = lprs_pkg::PH_DROP;
					hdr = '0;
					hdr_cnt = '0;
				end else if (hdr_cnt < lprs_pkg::HEADER_BYTES - 1) begin
					hdr[8 * hdr_cnt +: 8] = b;
					hdr_cnt++;
				end else begin
					len = longint'({b, hdr});
					if (len == 0 || base + lprs_pkg::HEADER_BYTES + len > lim) begin
						burst[n] = make_beat(8'h00, 1'b0, 1'b0, lprs_pkg::ST_INVALID);
						n++;
						split_phase = lprs_pkg::PH_DROP;
					end else if (len + lprs_pkg::HEADER_BYTES > longint'(max_rec)) begin
						burst[n] = make_beat(8'h00, 1'b0, 1'b0, lprs_pkg::ST_TOO_LARGE);
						n++;
						split_phase = lprs_pkg::PH_DROP;
					end else begin
						burst[0] = make_beat(hdr[7:0], 1'b1, 1'b0, lprs_pkg::ST_DATA);
						burst[1] = make_beat(hdr[15:8], 1'b0, 1'b0, lprs_pkg::ST_DATA);
						burst[2] = make_beat(hdr[23:16], 1'b0, 1'b0, lprs_pkg::ST_DATA);
						burst[3] = make_beat(b, 1'b0, 1'b0, lprs_pkg::ST_DATA);
						n = 4;
						body_left = 16'(len);
						split_phase = lprs_pkg::PH_BODY;
					end
					hdr = '0;
					hdr_cnt = '0;
				end
			end
			lprs_pkg::PH_BODY: begin
				done = (body_left <= 16'd1);
				burst[n] = make_beat(b, 1'b0, done, lprs_pkg::ST_DATA);
				n++;
				if (done) begin
					body_left = '0;
					split_phase = lprs_pkg::PH_HEADER;
					if (at_end) begin
						burst[n] = make_beat(8'h00, 1'b0, 1'b0, lprs_pkg::ST_CLEAN);
						n++;
					end
				end else begin
					body_left = body_left - 16'd1;
					if (at_end) begin
						burst[n] = make_beat(8'h00, 1'b0, 1'b0, lprs_pkg::ST_INVALID);
						n++;
					end
				end
			end
			default: ;
		endcase
		if (at_end) begin
			split_phase = lprs_pkg::PH_HEADER;
			offset = '0;
			hdr = '0;
			hdr_cnt = '0;
			body_left = '0;
		end else begin
			offset = offset + 16'd1;
		end
		if (n > 0)
			burst[n - 1].run_end = 1'b1;
		for (i = 0; i < n; i++)
			beats_due.insert(beats_due.size(), burst[i]);
	endfunction

	function automatic void note_bad(input string what, input logic has_want, input beat_t want,
		input beat_t got);
		mism++;
		if (mism <= MAX_REPORTS) begin
			if (has_want)
				$display("%0t %s: expected byte=%02h first=%b last=%b run_last=%b status=%0d",
					$time, what, want.data, want.first, want.last, want.run_end, want.status);
			else
				$display("%0t %s: expected none", $time, what);
			$display("%0t %s: actual   byte=%02h first=%b last=%b run_last=%b status=%0d",
				$time, what, got.data, got.first, got.last, got.run_end, got.status);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		beat_t got;
		beat_t want;
		if (!arst_n) begin
			split_phase = lprs_pkg::PH_HEADER;
			offset = '0;
			hdr = '0;
			hdr_cnt = '0;
			body_left = '0;
			max_rec = lprs_pkg::MAX_RECORD_RESET;
			beats_due.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				got.data = result_mon.out_byte;
				got.first = result_mon.record_first;
				got.last = result_mon.record_last;
				got.run_end = result_mon.run_last;
				got.status = lprs_pkg::status_t'(result_mon.status);
				if (beats_due.size() == 0) begin
					note_bad("unexpected result", 1'b0, got, got);
				end else begin
					want = beats_due.pop_front();
					if (got !== want)
						note_bad("result mismatch", 1'b1, want, got);
				end
			end
			if (psel && penable && pwrite && pready &&
				paddr == {lprs_pkg::REG_MAX_RECORD, 2'b00})
				max_rec = pwdata[15:0];
			if (item_mon.valid && item_mon.ready)
				split_byte(item_mon.byte_value, item_mon.payload_bytes, item_mon.payload_last);
			pending <= beats_due.size();
			fail_count <= mism;
		end
	end
endmodule

/* bench/length_prefixed_record_splitter_test.sv */
`timescale 1ns / 1ps
// Top of the record splitter bench: clock, reset, payload stimulus, APB writes, verdict.
// Depends on lprs_pkg, lprs_in_if, lprs_out_if, length_prefixed_record_splitter,
// lprs_record_checker.
module length_prefixed_record_splitter_test;

	localparam int HOLD_CYCLES      = 200;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RANDOM_PER_PHASE = 15;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lprs_pkg::PADDR_W-1:0]  paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;
	int unsigned                   fail_count;
	int unsigned                   pending;
	int                            send_idle_pct = 0;
	int                            stall_pct = 0;
	int                            hold_asked = 0;
	int                            sent = 0;
	int                            quiet_cycles = 0;
	logic [7:0]                    pay_q[$];

	lprs_in_if  item_ch ();
	lprs_out_if result_ch ();

	length_prefixed_record_splitter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lprs_record_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_mon   (item_ch),
		.result_mon (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : receiver
		int hold_served;
		int k;
		hold_served = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				result_ch.ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic void queue_byte(input logic [7:0] b);
		pay_q.insert(pay_q.size(), b);
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic [15:0] pb, input logic mark);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_ch.valid <= 1'b1;
		item_ch.byte_value <= b;
		item_ch.payload_bytes <= pb;
		item_ch.payload_last <= mark;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_payload(input logic [15:0] pb, input logic mark);
		int i;
		for (i = 0; i < pay_q.size(); i++)
			put_byte(pay_q[i], pb, mark && (i == pay_q.size() - 1));
		pay_q.delete();
	endtask

	task automatic add_header(input logic [31:0] len);
		queue_byte(len[7:0]);
		queue_byte(len[15:8]);
		queue_byte(len[23:16]);
		queue_byte(len[31:24]);
	endtask

	task automatic add_body(input int n);
		int i;
		for (i = 0; i < n; i++)
			queue_byte(8'($urandom));
	endtask

	task automatic write_max_record(input logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {lprs_pkg::REG_MAX_RECORD, 2'b00};
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_random_payload();
		int kind;
		int nrec;
		int k;
		int body;
		kind = $urandom_range(9);
		if (kind <= 5) begin
			nrec = $urandom_range(1, 3);
			for (k = 0; k < nrec; k++) begin
				body = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				add_header(32'(body));
				add_body(body);
			end
			if ($urandom_range(1))
				send_payload(16'(pay_q.size()), 1'($urandom_range(1)));
			else
				send_payload(16'($urandom_range(65535, pay_q.size())), 1'b1);
		end else if (kind == 6) begin
			body = $urandom_range(1, 4);
			add_header(32'(body));
			add_body(body);
			add_header(32'd0);
			add_body(3);
			send_payload(16'(pay_q.size()), 1'($urandom_range(1)));
		end else if (kind == 7) begin
			body = $urandom_range(1, 6);
			add_header(32'(body));
			add_body(body);
			// short tail, or a header that runs past the end
			if ($urandom_range(1)) begin
				add_body($urandom_range(1, 4));
			end else begin
				body = $urandom_range(1, 6);
				add_header($urandom_range(1) ? 32'(body + $urandom_range(1, 8)) : $urandom);
				add_body(body);
			end
			send_payload(16'(pay_q.size()), 1'($urandom_range(1)));
		end else if (kind == 8) begin
			body = $urandom_range(2, 10);
			add_header(32'(body));
			add_body($urandom_range(1, body - 1));
			send_payload(16'($urandom_range(65535, pay_q.size() + body)), 1'b1);
		end else begin
			add_body($urandom_range(1, 8));
			send_payload($urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(9)),
				1'($urandom_range(3) != 0));
		end
	endtask

	initial begin : stimulus
		int ph_i;
		int k;
		int start;
		item_ch.valid = 1'b0;
		item_ch.byte_value = '0;
		item_ch.payload_bytes = '0;
		item_ch.payload_last = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (ph_i = 0; ph_i < 4; ph_i++) begin
			case (ph_i)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
					write_max_record(16'hFFFF);
				end
				1: begin
					send_idle_pct = 69;
					stall_pct <= 0;
					write_max_record(16'd12);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 69;
					write_max_record(16'd5);
				end
				default: begin
					send_idle_pct = 36;
					stall_pct <= 36;
					write_max_record(16'd3);
				end
			endcase
			if (ph_i == 0) begin
				add_header(32'd1);
				queue_byte(8'hFF);
				send_payload(16'd5, 1'b1);
				add_header(32'd0);
				add_body(1);
				send_payload(16'd5, 1'b0);
				queue_byte(8'hFF);
				queue_byte(8'h00);
				send_payload(16'd2, 1'b0);
				queue_byte(8'hA5);
				send_payload(16'd0, 1'b0);
				// body cut short by the last mark
				add_header(32'd3);
				add_body(1);
				send_payload(16'hFFFF, 1'b1);
				add_header(32'hFFFF_FFFF);
				add_body(1);
				send_payload(16'd5, 1'b0);
				// hold off the receiver while records keep coming
				hold_asked <= hold_asked + 1;
				for (k = 0; k < 3; k++) begin
					add_header(32'd8);
					add_body(8);
					send_payload(16'd12, 1'b1);
				end
			end
			start = sent;
			while (sent - start < RANDOM_PER_PHASE)
				send_random_payload();
			item_ch.valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
